FILE: rtl/segment_intersect_point_distance_assert.svh
// Assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECT_POINT_DISTANCE_ASSERT_SVH
`define SEGMENT_INTERSECT_POINT_DISTANCE_ASSERT_SVH

// same-cycle implication
`define SIPD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sipd assertion failed");

// next-cycle implication
`define SIPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sipd assertion failed");

`endif

FILE: rtl/sipd_pkg.sv
package sipd_pkg;

  localparam int CoordBits     = 16;
  localparam int RatioFracBits = 16;
  localparam int DiffBits      = CoordBits + 1;
  localparam int ProdBits      = 2 * DiffBits;
  localparam int CrossBits     = ProdBits + 1;
  localparam int MagBits       = ProdBits;
  localparam int RemBits       = MagBits + 1;
  localparam int RootBits      = DiffBits;
  localparam int SqSteps       = RootBits;
  localparam int IterSteps     = (RatioFracBits > SqSteps) ? RatioFracBits : SqSteps;
  localparam int DistBits      = 17;
  localparam int ScaleBits     = DiffBits + RatioFracBits + 1;
  localparam int DprodBits     = RootBits + RatioFracBits;

  typedef struct packed {
    logic signed [CoordBits-1:0] first_start_x;
    logic signed [CoordBits-1:0] first_start_y;
    logic signed [CoordBits-1:0] first_end_x;
    logic signed [CoordBits-1:0] first_end_y;
    logic signed [CoordBits-1:0] second_start_x;
    logic signed [CoordBits-1:0] second_start_y;
    logic signed [CoordBits-1:0] second_end_x;
    logic signed [CoordBits-1:0] second_end_y;
  } seg_req_t;

  typedef struct packed {
    logic                        hit;
    logic signed [CoordBits-1:0] hit_x;
    logic signed [CoordBits-1:0] hit_y;
    logic [DistBits-1:0]         hit_distance;
  } seg_rsp_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [DiffBits-1:0]  abx;
    logic signed [DiffBits-1:0]  aby;
    logic                        ok;
  } side_t;

  typedef struct packed {
    logic                     valid;
    side_t                    side;
    logic [MagBits-1:0]       den;
    logic [RemBits-1:0]       rrem;
    logic [RemBits-1:0]       srem;
    logic [RatioFracBits-1:0] rq;
    logic [RatioFracBits-1:0] sq;
    logic [MagBits-1:0]       sv;
    logic [MagBits-1:0]       sres;
  } iter_t;

  function automatic logic signed [DiffBits-1:0] sx(input logic signed [CoordBits-1:0] a);
    sx = {a[CoordBits-1], a};
  endfunction

  function automatic logic signed [CrossBits-1:0] px(input logic signed [ProdBits-1:0] a);
    px = {a[ProdBits-1], a};
  endfunction

  function automatic logic [MagBits-1:0] mag(input logic signed [CrossBits-1:0] a);
    logic signed [CrossBits-1:0] n;
    n = -a;
    mag = a[CrossBits-1] ? n[MagBits-1:0] : a[MagBits-1:0];
  endfunction

endpackage

FILE: rtl/segment_intersect_point_distance.sv
// Segment crossing test for 2D segments in signed Q11.4.
// Request channel: in_valid_i / in_stall_o with in_req_i carrying A, B (first
// segment) and C, D (second segment). A request is taken at a rising edge with
// in_valid_i high and in_stall_o low.
// Response channel: out_valid_o / out_stall_i with out_rsp_o carrying hit,
// hit_x, hit_y and hit_distance; all fields are zero on a miss.
// The pipeline computes differences, products, cross terms and range checks,
// then runs the stepped divider and square root (one root bit per stage, and one
// quotient bit per stage up to RatioFracBits), then scales and rounds.
// Throughput is one request per cycle while the output is not stalled.
// The whole pipeline advances on one enable; it holds while a valid response
// sits at the output and out_stall_i is high, and in_stall_o is raised then.
// Reset clears every valid bit; no response is pending after reset.
module segment_intersect_point_distance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sipd_pkg::seg_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sipd_pkg::seg_rsp_t out_rsp_o
);
  import sipd_pkg::*;

  logic  en;
  iter_t front_item, iter_item;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  sipd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .req_i  (in_req_i),
    .item_o (front_item)
  );

  sipd_iter u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .item_i(front_item),
    .item_o(iter_item)
  );

  sipd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .item_i (iter_item),
    .valid_o(out_valid_o),
    .rsp_o  (out_rsp_o)
  );

`include "segment_intersect_point_distance_assert.svh"

  `SIPD_ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, out_valid_o && !out_rsp_o.hit, out_rsp_o.hit_x == '0 && out_rsp_o.hit_y == '0 && out_rsp_o.hit_distance == '0)
  `SIPD_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `SIPD_ASSERT_NEXT(a_front_hold, clk_i, rst_ni, in_stall_o, $stable(front_item) && $stable(iter_item))

endmodule

FILE: rtl/sipd_front.sv
module sipd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sipd_pkg::seg_req_t req_i,
  output sipd_pkg::iter_t   item_o
);
  import sipd_pkg::*;

  // stage 1: differences
  logic                        v1_q;
  logic signed [CoordBits-1:0] ax1_q, ay1_q;
  logic signed [DiffBits-1:0]  abx1_q, aby1_q, cdx1_q, cdy1_q, acx1_q, acy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= req_i.first_start_x;
      ay1_q  <= req_i.first_start_y;
      abx1_q <= sx(req_i.first_end_x) - sx(req_i.first_start_x);
      aby1_q <= sx(req_i.first_end_y) - sx(req_i.first_start_y);
      cdx1_q <= sx(req_i.second_end_x) - sx(req_i.second_start_x);
      cdy1_q <= sx(req_i.second_end_y) - sx(req_i.second_start_y);
      acx1_q <= sx(req_i.first_start_x) - sx(req_i.second_start_x);
      acy1_q <= sx(req_i.first_start_y) - sx(req_i.second_start_y);
    end
  end

  // stage 2: products
  logic                        v2_q;
  logic signed [CoordBits-1:0] ax2_q, ay2_q;
  logic signed [DiffBits-1:0]  abx2_q, aby2_q;
  logic signed [ProdBits-1:0]  p_den_a_q, p_den_b_q, p_r_a_q, p_r_b_q, p_s_a_q, p_s_b_q;
  logic signed [ProdBits-1:0]  sq_x_q, sq_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax2_q     <= ax1_q;
      ay2_q     <= ay1_q;
      abx2_q    <= abx1_q;
      aby2_q    <= aby1_q;
      p_den_a_q <= abx1_q * cdy1_q;
      p_den_b_q <= aby1_q * cdx1_q;
      p_r_a_q   <= acy1_q * cdx1_q;
      p_r_b_q   <= acx1_q * cdy1_q;
      p_s_a_q   <= acy1_q * abx1_q;
      p_s_b_q   <= acx1_q * aby1_q;
      sq_x_q    <= abx1_q * abx1_q;
      sq_y_q    <= aby1_q * aby1_q;
    end
  end

  // stage 3: cross terms
  logic                         v3_q;
  logic signed [CoordBits-1:0]  ax3_q, ay3_q;
  logic signed [DiffBits-1:0]   abx3_q, aby3_q;
  logic signed [CrossBits-1:0]  den3_q, rnum3_q, snum3_q;
  logic [MagBits-1:0]           sqsum3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax3_q    <= ax2_q;
      ay3_q    <= ay2_q;
      abx3_q   <= abx2_q;
      aby3_q   <= aby2_q;
      den3_q   <= px(p_den_a_q) - px(p_den_b_q);
      rnum3_q  <= px(p_r_a_q) - px(p_r_b_q);
      snum3_q  <= px(p_s_a_q) - px(p_s_b_q);
      sqsum3_q <= $unsigned(sq_x_q) + $unsigned(sq_y_q);
    end
  end

  // stage 4: magnitudes and range checks
  logic [MagBits-1:0] den_m, rnum_m, snum_m;
  logic               r_ok, s_ok;
  iter_t              item_d, item_q;

  always_comb begin
    den_m  = mag(den3_q);
    rnum_m = mag(rnum3_q);
    snum_m = mag(snum3_q);
    r_ok   = (den3_q != '0) && (rnum3_q != '0) &&
             (rnum3_q[CrossBits-1] == den3_q[CrossBits-1]) && (rnum_m < den_m);
    s_ok   = (den3_q != '0) && (snum3_q != '0) &&
             (snum3_q[CrossBits-1] == den3_q[CrossBits-1]) && (snum_m < den_m);
    item_d          = '0;
    item_d.valid    = v3_q;
    item_d.side.ax  = ax3_q;
    item_d.side.ay  = ay3_q;
    item_d.side.abx = abx3_q;
    item_d.side.aby = aby3_q;
    item_d.side.ok  = r_ok && s_ok;
    item_d.den      = den_m;
    item_d.rrem     = {1'b0, rnum_m};
    item_d.srem     = {1'b0, snum_m};
    item_d.sv       = sqsum3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: rtl/sipd_iter.sv
module sipd_iter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  sipd_pkg::iter_t item_i,
  output sipd_pkg::iter_t item_o
);
  import sipd_pkg::*;

  iter_t pipe_q [IterSteps];

  for (genvar k = 0; k < IterSteps; k++) begin : g_step
    iter_t cur, nxt;
    logic [RemBits-1:0] rsh, ssh;
    logic [MagBits-1:0] bitv;
    logic [MagBits:0]   trial;

    if (k == 0) begin : g_first
      assign cur = item_i;
    end else begin : g_rest
      assign cur = pipe_q[k-1];
    end

    always_comb begin
      nxt   = cur;
      rsh   = {cur.rrem[RemBits-2:0], 1'b0};
      ssh   = {cur.srem[RemBits-2:0], 1'b0};
      bitv  = MagBits'(1) << (2 * (SqSteps - 1 - k));
      trial = {1'b0, cur.sres} + {1'b0, bitv};
      // restoring division step, r and s in parallel
      if (k < RatioFracBits) begin
        if (rsh >= {1'b0, cur.den}) begin
          nxt.rrem = rsh - {1'b0, cur.den};
          nxt.rq   = {cur.rq[RatioFracBits-2:0], 1'b1};
        end else begin
          nxt.rrem = rsh;
          nxt.rq   = {cur.rq[RatioFracBits-2:0], 1'b0};
        end
        if (ssh >= {1'b0, cur.den}) begin
          nxt.srem = ssh - {1'b0, cur.den};
          nxt.sq   = {cur.sq[RatioFracBits-2:0], 1'b1};
        end else begin
          nxt.srem = ssh;
          nxt.sq   = {cur.sq[RatioFracBits-2:0], 1'b0};
        end
      end
      // square root digit
      if (k < SqSteps) begin
        if ({1'b0, cur.sv} >= trial) begin
          nxt.sv   = cur.sv - trial[MagBits-1:0];
          nxt.sres = (cur.sres >> 1) + bitv;
        end else begin
          nxt.sres = cur.sres >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[k] <= '0;
      end else if (en_i) begin
        pipe_q[k] <= nxt;
      end
    end
  end

  assign item_o = pipe_q[IterSteps-1];

endmodule

FILE: rtl/sipd_back.sv
module sipd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sipd_pkg::iter_t    item_i,
  output logic               valid_o,
  output sipd_pkg::seg_rsp_t rsp_o
);
  import sipd_pkg::*;

  // stage A: scale by r
  logic                        va_q, hit_a_q;
  logic signed [CoordBits-1:0] ax_a_q, ay_a_q;
  logic signed [ScaleBits-1:0] sx_a_q, sy_a_q;
  logic [DprodBits-1:0]        dp_a_q;
  logic signed [RatioFracBits:0] r_s;

  assign r_s = {1'b0, item_i.rq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_a_q <= item_i.side.ok && (item_i.rq != '0) && (item_i.sq != '0);
      ax_a_q  <= item_i.side.ax;
      ay_a_q  <= item_i.side.ay;
      sx_a_q  <= item_i.side.abx * r_s;
      sy_a_q  <= item_i.side.aby * r_s;
      dp_a_q  <= item_i.sres[RootBits-1:0] * item_i.rq;
    end
  end

  // stage B: round, offset, saturate
  logic signed [ScaleBits-1:0] rx, ry;
  logic [DprodBits:0]          dsum;
  logic [DprodBits:0]          dist_sh;
  seg_rsp_t                    rsp_d, rsp_q;
  logic                        vb_q;

  always_comb begin
    rx   = (sx_a_q + (ScaleBits'(1) << (RatioFracBits - 1))) >>> RatioFracBits;
    ry   = (sy_a_q + (ScaleBits'(1) << (RatioFracBits - 1))) >>> RatioFracBits;
    dsum = {1'b0, dp_a_q} + ((DprodBits + 1)'(1) << (RatioFracBits - 1));
    dist_sh = dsum >> RatioFracBits;
    rsp_d = '0;
    if (hit_a_q) begin
      rsp_d.hit   = 1'b1;
      rsp_d.hit_x = ax_a_q + rx[CoordBits-1:0];
      rsp_d.hit_y = ay_a_q + ry[CoordBits-1:0];
      if (dist_sh > (DprodBits + 1)'({DistBits{1'b1}})) begin
        rsp_d.hit_distance = '1;
      end else begin
        rsp_d.hit_distance = dist_sh[DistBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = vb_q;
  assign rsp_o   = rsp_q;

endmodule
